[design/cmm_pkg.sv]
// Shared types, constants and codes of the complex matrix multiplier.
`default_nettype none
package cmm_pkg;

    // Element and accumulator formats.
    localparam int DATA_WIDTH  = 16;
    localparam int ACC_WIDTH   = 40;
    localparam int MAX_DIM_DEF = 8;
    localparam int IDX_WIDTH   = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_ENABLE = 3'd4;

    // Command codes.
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]                   command;
        logic [IDX_WIDTH-1:0]         row;
        logic [IDX_WIDTH-1:0]         col;
        logic signed [DATA_WIDTH-1:0] value_re;
        logic signed [DATA_WIDTH-1:0] value_im;
    } cmm_in_t;

    typedef struct packed {
        logic [IDX_WIDTH-1:0]        out_row;
        logic [IDX_WIDTH-1:0]        out_col;
        logic signed [ACC_WIDTH-1:0] out_re;
        logic signed [ACC_WIDTH-1:0] out_im;
        logic                        last;
    } cmm_out_t;

    // Travels with each memory read through the multiply-accumulate pipe.
    typedef struct packed {
        logic                 first_k;
        logic                 last_k;
        logic                 last_elem;
        logic [IDX_WIDTH-1:0] row;
        logic [IDX_WIDTH-1:0] col;
    } cmm_tag_t;

    typedef struct packed {
        logic use_re;
        logic use_im;
    } cmm_mode_t;

endpackage
`default_nettype wire

[design/complex_matrix_multiply.sv]
// Top level of the complex matrix multiplier: registers, load decode and control.
//
// Channel   Signals                                   Direction  Handshake
// command   start, busy, item                         in         taken when start && !busy
// result    result_valid, result                      out        one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in         taken when valid && ready
//
// A load is written to the element memory at the edge it is taken. A compute, if a part
// is enabled, raises busy until its last result word is out: the sequencer issues one
// (row, col, k) read of both memories per cycle, followed by a three-stage read,
// multiply and accumulate pipe. One result word leaves after each completed inner sum.
// Reset clears control state and sets the registers to full 8x8x8 complex mode; the
// memories are not cleared. The receiver cannot stall, so results are never held.
`default_nettype none
module complex_matrix_multiply #(
    parameter int MAX_DIM = cmm_pkg::MAX_DIM_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire cmm_pkg::cmm_in_t                item,
    output logic                                 result_valid,
    output cmm_pkg::cmm_out_t                    result,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cmm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cmm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW     = 2 * DATA_WIDTH;

    logic [3:0]        rows_a_reg;
    logic [3:0]        inner_size_reg;
    logic [3:0]        cols_b_reg;
    logic              real_enable_reg;
    logic              imag_enable_reg;
    logic              busy_reg;
    logic              busy_next;
    logic              accept;
    logic              go;
    logic              load_ok;
    logic [6:0]        lin_w;
    logic [ADDR_W-1:0] waddr;
    logic [MW-1:0]     wdata;
    logic [DIM_W-1:0]  nr_m1;
    logic [DIM_W-1:0]  nk_m1;
    logic [DIM_W-1:0]  nc_m1;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [MW-1:0]     a_data;
    logic [MW-1:0]     b_data;
    logic              issue;
    cmm_tag_t          tag;
    cmm_mode_t         mode;

    // A zero dimension counts as 1 and anything above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] dim_m1(input logic [3:0] d);
        logic [3:0] v;
        begin
            if (d == 4'd0)
            begin
                v = 4'd0;
            end
            else if ({1'b0, d} > 5'(MAX_DIM))
            begin
                v = 4'(MAX_DIM - 1);
            end
            else
            begin
                v = d - 4'd1;
            end
            dim_m1 = v[DIM_W-1:0];
        end
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg      <= 4'd8;
            inner_size_reg  <= 4'd8;
            cols_b_reg      <= 4'd8;
            real_enable_reg <= 1'b1;
            imag_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROWS_A:      rows_a_reg      <= cfg_data;
                REG_INNER_SIZE:  inner_size_reg  <= cfg_data;
                REG_COLS_B:      cols_b_reg      <= cfg_data;
                REG_REAL_ENABLE: real_enable_reg <= cfg_data[0];
                REG_IMAG_ENABLE: imag_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign accept = start && !busy_reg;
    assign go     = accept && (item.command == CMD_COMPUTE)
                    && (real_enable_reg || imag_enable_reg);

    // Loads outside the memory's rows or columns are dropped.
    assign load_ok = ({1'b0, item.row} < 4'(MAX_DIM)) && ({1'b0, item.col} < 4'(MAX_DIM));
    assign lin_w   = 7'(item.row) * 7'(MAX_DIM) + 7'(item.col);
    assign waddr   = lin_w[ADDR_W-1:0];
    assign wdata   = {item.value_re, item.value_im};

    always_comb
    begin
        busy_next = busy_reg;
        if (go)
        begin
            busy_next = 1'b1;
        end
        else if (result_valid && result.last)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy  = busy_reg;
    assign nr_m1 = dim_m1(rows_a_reg);
    assign nk_m1 = dim_m1(inner_size_reg);
    assign nc_m1 = dim_m1(cols_b_reg);
    assign mode.use_re = real_enable_reg;
    assign mode.use_im = imag_enable_reg;

    cmm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (MW)
    ) u_mem_a (
        .clk   (clk),
        .we    (accept && (item.command == CMD_LOAD_A) && load_ok),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr_a),
        .rdata (a_data)
    );

    cmm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .WIDTH  (MW)
    ) u_mem_b (
        .clk   (clk),
        .we    (accept && (item.command == CMD_LOAD_B) && load_ok),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr_b),
        .rdata (b_data)
    );

    cmm_seq #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .nr_m1  (nr_m1),
        .nk_m1  (nk_m1),
        .nc_m1  (nc_m1),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .issue  (issue),
        .tag    (tag)
    );

    cmm_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .tag          (tag),
        .mode         (mode),
        .a_data       (a_data),
        .b_data       (b_data),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_result_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy_reg)
        else $error("result word outside a compute");

    a_issue_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> busy_reg)
        else $error("memory read issued while idle");

    a_go_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy_reg)
        else $error("compute taken but busy not raised");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !busy_reg && !result_valid)
        else $error("activity after final result word");
`endif

endmodule
`default_nettype wire

[design/cmm_mem.sv]
// Synchronous element memory with one write port and one registered read port.
`default_nettype none
module cmm_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[design/cmm_seq.sv]
// Walks columns, rows and the inner index and issues the memory read addresses.
`default_nettype none
module cmm_seq #(
    parameter int MAX_DIM = 8,
    parameter int DIM_W   = 3,
    parameter int ADDR_W  = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  go,
    input  wire logic [DIM_W-1:0]      nr_m1,
    input  wire logic [DIM_W-1:0]      nk_m1,
    input  wire logic [DIM_W-1:0]      nc_m1,
    output logic      [ADDR_W-1:0]     addr_a,
    output logic      [ADDR_W-1:0]     addr_b,
    output logic                       issue,
    output cmm_pkg::cmm_tag_t          tag
);
    import cmm_pkg::*;

    logic             active_reg;
    logic [DIM_W-1:0] c_reg;
    logic [DIM_W-1:0] r_reg;
    logic [DIM_W-1:0] k_reg;
    logic [6:0]       lin_a;
    logic [6:0]       lin_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            c_reg      <= '0;
            r_reg      <= '0;
            k_reg      <= '0;
        end
        else if (go)
        begin
            active_reg <= 1'b1;
            c_reg      <= '0;
            r_reg      <= '0;
            k_reg      <= '0;
        end
        else if (active_reg)
        begin
            if (k_reg == nk_m1)
            begin
                k_reg <= '0;
                if (r_reg == nr_m1)
                begin
                    r_reg <= '0;
                    if (c_reg == nc_m1)
                    begin
                        active_reg <= 1'b0;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                else
                begin
                    r_reg <= r_reg + 1'b1;
                end
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // A is addressed at (row, k), B at (k, col).
    assign lin_a  = 7'(r_reg) * 7'(MAX_DIM) + 7'(k_reg);
    assign lin_b  = 7'(k_reg) * 7'(MAX_DIM) + 7'(c_reg);
    assign addr_a = lin_a[ADDR_W-1:0];
    assign addr_b = lin_b[ADDR_W-1:0];
    assign issue  = active_reg;

    always_comb
    begin
        tag.first_k   = (k_reg == '0);
        tag.last_k    = (k_reg == nk_m1);
        tag.last_elem = (r_reg == nr_m1) && (c_reg == nc_m1);
        tag.row       = IDX_WIDTH'(r_reg);
        tag.col       = IDX_WIDTH'(c_reg);
    end

endmodule
`default_nettype wire

[design/cmm_mac.sv]
// Complex multiply-accumulate pipeline and the registered result word.
`default_nettype none
module cmm_mac (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  issue,
    input  wire cmm_pkg::cmm_tag_t                     tag,
    input  wire cmm_pkg::cmm_mode_t                    mode,
    input  wire logic [2*cmm_pkg::DATA_WIDTH-1:0]      a_data,
    input  wire logic [2*cmm_pkg::DATA_WIDTH-1:0]      b_data,
    output logic                                       result_valid,
    output cmm_pkg::cmm_out_t                          result
);
    import cmm_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;

    logic                          v1_reg;
    cmm_tag_t                      tag1_reg;
    logic                          v2_reg;
    cmm_tag_t                      tag2_reg;
    logic signed [PW-1:0]          p_rr_reg;
    logic signed [PW-1:0]          p_ii_reg;
    logic signed [PW-1:0]          p_ri_reg;
    logic signed [PW-1:0]          p_ir_reg;
    logic signed [ACC_WIDTH-1:0]   acc_re_reg;
    logic signed [ACC_WIDTH-1:0]   acc_im_reg;
    logic signed [DATA_WIDTH-1:0]  a_re;
    logic signed [DATA_WIDTH-1:0]  a_im;
    logic signed [DATA_WIDTH-1:0]  b_re;
    logic signed [DATA_WIDTH-1:0]  b_im;
    logic signed [ACC_WIDTH-1:0]   term_re;
    logic signed [ACC_WIDTH-1:0]   term_im;
    logic signed [ACC_WIDTH-1:0]   sum_re;
    logic signed [ACC_WIDTH-1:0]   sum_im;
    logic                          valid_reg;
    cmm_out_t                      result_reg;

    assign a_re = a_data[PW-1:DATA_WIDTH];
    assign a_im = a_data[DATA_WIDTH-1:0];
    assign b_re = b_data[PW-1:DATA_WIDTH];
    assign b_im = b_data[DATA_WIDTH-1:0];

    // Stage 1: memory data arrives in the cycle after the address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= tag;
        tag2_reg <= tag1_reg;
        p_rr_reg <= a_re * b_re;
        p_ii_reg <= a_im * b_im;
        p_ri_reg <= a_re * b_im;
        p_ir_reg <= a_im * b_re;
    end

    // In single-part modes the unused product drops out and the imaginary sum stays 0.
    always_comb
    begin
        term_re = (mode.use_re ? ACC_WIDTH'(p_rr_reg) : '0)
                - (mode.use_im ? ACC_WIDTH'(p_ii_reg) : '0);
        term_im = (mode.use_re && mode.use_im)
                ? ACC_WIDTH'(p_ri_reg) + ACC_WIDTH'(p_ir_reg) : '0;
        sum_re  = (tag2_reg.first_k ? '0 : acc_re_reg) + term_re;
        sum_im  = (tag2_reg.first_k ? '0 : acc_im_reg) + term_im;
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            acc_re_reg <= sum_re;
            acc_im_reg <= sum_im;
        end
        if (v2_reg && tag2_reg.last_k)
        begin
            result_reg.out_row <= tag2_reg.row;
            result_reg.out_col <= tag2_reg.col;
            result_reg.out_re  <= sum_re;
            result_reg.out_im  <= sum_im;
            result_reg.last    <= tag2_reg.last_elem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= v2_reg && tag2_reg.last_k;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

[verif/cmm_product_checker.sv]
// Checker for the complex matrix multiplier: predicts each product word and compares it.
`timescale 1ns / 1ps
module cmm_product_checker
    import cmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  cmm_in_t               item,
    input  logic                  result_valid,
    input  cmm_out_t              result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    words_pending,
    output int                    words_checked
);

    localparam int DIM = MAX_DIM_DEF;

    logic signed [DATA_WIDTH-1:0] a_re_mem [DIM*DIM];
    logic signed [DATA_WIDTH-1:0] a_im_mem [DIM*DIM];
    logic signed [DATA_WIDTH-1:0] b_re_mem [DIM*DIM];
    logic signed [DATA_WIDTH-1:0] b_im_mem [DIM*DIM];

    logic [3:0] rows_reg;
    logic [3:0] inner_reg;
    logic [3:0] cols_reg;
    logic       real_en;
    logic       imag_en;

    cmm_out_t product_q[$];

    function automatic int eff_dim(logic [3:0] d);
        if (d == 4'd0)
            return 1;
        if (d > DIM)
            return DIM;
        return int'(d);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[checker] %0d ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Queues one word per element of C, walking columns outside and rows inside.
    task automatic predict_product();
        int       nr;
        int       nk;
        int       nc;
        longint   sum_re;
        longint   sum_im;
        longint   ar;
        longint   ai;
        longint   br;
        longint   bi;
        cmm_out_t w;
        if (!real_en && !imag_en)
            return;
        nr = eff_dim(rows_reg);
        nk = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        for (int c = 0; c < nc; c++)
        begin
            for (int r = 0; r < nr; r++)
            begin
                sum_re = 0;
                sum_im = 0;
                for (int k = 0; k < nk; k++)
                begin
                    ar = a_re_mem[r*DIM + k];
                    ai = a_im_mem[r*DIM + k];
                    br = b_re_mem[k*DIM + c];
                    bi = b_im_mem[k*DIM + c];
                    if (real_en && imag_en)
                    begin
                        sum_re += ar * br - ai * bi;
                        sum_im += ar * bi + ai * br;
                    end
                    else if (real_en)
                        sum_re += ar * br;
                    else
                        sum_re -= ai * bi;
                end
                w.out_row = IDX_WIDTH'(r);
                w.out_col = IDX_WIDTH'(c);
                w.out_re  = sum_re[ACC_WIDTH-1:0];
                w.out_im  = sum_im[ACC_WIDTH-1:0];
                w.last    = (c == nc - 1) && (r == nr - 1);
                product_q.push_back(w);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmm_out_t want;
        int       idx;
        if (!rst_n)
        begin
            rows_reg       = 4'd8;
            inner_reg      = 4'd8;
            cols_reg       = 4'd8;
            real_en        = 1'b1;
            imag_en        = 1'b1;
            mismatch_count = 0;
            words_checked  = 0;
            product_q.delete();
            words_pending <= 0;
        end
        else
        begin
            // Words leaving at this edge belong to products accepted earlier.
            if (result_valid)
            begin
                if (product_q.size() == 0)
                    report_mismatch($sformatf("word row %0d col %0d arrived with nothing expected",
                                              result.out_row, result.out_col));
                else
                begin
                    want = product_q.pop_front();
                    words_checked++;
                    if (result.out_row !== want.out_row)
                        report_mismatch($sformatf("out_row: expected %0d, got %0d",
                                                  want.out_row, result.out_row));
                    if (result.out_col !== want.out_col)
                        report_mismatch($sformatf("out_col: expected %0d, got %0d",
                                                  want.out_col, result.out_col));
                    if (result.out_re !== want.out_re)
                        report_mismatch($sformatf("out_re at (%0d,%0d): expected %0d, got %0d",
                                                  want.out_row, want.out_col,
                                                  want.out_re, result.out_re));
                    if (result.out_im !== want.out_im)
                        report_mismatch($sformatf("out_im at (%0d,%0d): expected %0d, got %0d",
                                                  want.out_row, want.out_col,
                                                  want.out_im, result.out_im));
                    if (result.last !== want.last)
                        report_mismatch($sformatf("last at (%0d,%0d): expected %0d, got %0d",
                                                  want.out_row, want.out_col,
                                                  want.last, result.last));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS_A:      rows_reg  = cfg_data;
                    REG_INNER_SIZE:  inner_reg = cfg_data;
                    REG_COLS_B:      cols_reg  = cfg_data;
                    REG_REAL_ENABLE: real_en   = cfg_data[0];
                    REG_IMAG_ENABLE: imag_en   = cfg_data[0];
                    default: ;
                endcase
            end

            if (start && !busy)
            begin
                idx = int'(item.row) * DIM + int'(item.col);
                case (item.command)
                    CMD_LOAD_A:
                    begin
                        a_re_mem[idx] = item.value_re;
                        a_im_mem[idx] = item.value_im;
                    end
                    CMD_LOAD_B:
                    begin
                        b_re_mem[idx] = item.value_re;
                        b_im_mem[idx] = item.value_im;
                    end
                    CMD_COMPUTE: predict_product();
                    default: ;
                endcase
            end

            words_pending <= product_q.size();
        end
    end

endmodule

[verif/tb_complex_matrix_multiply.sv]
// Testbench top for the complex matrix multiplier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_complex_matrix_multiply;
    import cmm_pkg::*;

    localparam int DIM         = MAX_DIM_DEF;
    localparam int ITEM_TARGET = 410;
    localparam int CALM_FROM   = 360;
    localparam int STALL_LIMIT = 5000;

    localparam logic [1:0]           CMD_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END  = REG_IMAG_ENABLE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    cmm_in_t               item;
    logic                  result_valid;
    cmm_out_t              result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatch_count;
    int words_pending;
    int words_checked;

    // Shape as last written, and which elements hold data, so that no product reads an
    // element that was never loaded.
    logic [3:0] rows_set;
    logic [3:0] inner_set;
    logic [3:0] cols_set;
    logic       a_loaded [DIM*DIM];
    logic       b_loaded [DIM*DIM];

    bit idling_on;
    int cmd_count;
    int product_count;
    int ignored_count;
    int reg_write_count;
    int quiet_cycles;

    complex_matrix_multiply u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cmm_product_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .result_valid   (result_valid),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no channel activity for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int used_dim(logic [3:0] d);
        if (d == 4'd0)
            return 1;
        if (d > DIM)
            return DIM;
        return int'(d);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return DATA_WIDTH'($urandom());
        endcase
    endfunction

    function automatic logic [3:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 4'd0;
            1: return 4'($urandom_range(9, 15));
            2: return 4'd8;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic idle_burst();
        if (idling_on && cmd_count < CALM_FROM && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Holds one command word on the port until the block takes it.
    task automatic issue(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                         logic [DATA_WIDTH-1:0] re, logic [DATA_WIDTH-1:0] im);
        cmm_in_t w;
        idle_burst();
        w.command  = cmd;
        w.row      = r;
        w.col      = c;
        w.value_re = re;
        w.value_im = im;
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        case (cmd)
            CMD_LOAD_A:
            begin
                a_loaded[int'(r)*DIM + int'(c)] = 1'b1;
                cmd_count++;
            end
            CMD_LOAD_B:
            begin
                b_loaded[int'(r)*DIM + int'(c)] = 1'b1;
                cmd_count++;
            end
            CMD_COMPUTE:
            begin
                product_count++;
                cmd_count++;
            end
            default: ignored_count++;
        endcase
    endtask

    task automatic load_random(bit inside_shape);
        int nr;
        int nk;
        int nc;
        nr = used_dim(rows_set);
        nk = used_dim(inner_set);
        nc = used_dim(cols_set);
        if ($urandom_range(0, 1) == 0)
        begin
            if (inside_shape)
                issue(CMD_LOAD_A, 3'($urandom_range(0, nr - 1)), 3'($urandom_range(0, nk - 1)),
                      random_value(), random_value());
            else
                issue(CMD_LOAD_A, 3'($urandom()), 3'($urandom()), random_value(), random_value());
        end
        else
        begin
            if (inside_shape)
                issue(CMD_LOAD_B, 3'($urandom_range(0, nk - 1)), 3'($urandom_range(0, nc - 1)),
                      random_value(), random_value());
            else
                issue(CMD_LOAD_B, 3'($urandom()), 3'($urandom()), random_value(), random_value());
        end
    endtask

    // Loads whatever the current shape reads but has not been written, then computes.
    task automatic compute_product();
        int nr;
        int nk;
        int nc;
        nr = used_dim(rows_set);
        nk = used_dim(inner_set);
        nc = used_dim(cols_set);
        for (int r = 0; r < nr; r++)
            for (int k = 0; k < nk; k++)
                if (!a_loaded[r*DIM + k])
                    issue(CMD_LOAD_A, 3'(r), 3'(k), random_value(), random_value());
        for (int k = 0; k < nk; k++)
            for (int c = 0; c < nc; c++)
                if (!b_loaded[k*DIM + c])
                    issue(CMD_LOAD_B, 3'(k), 3'(c), random_value(), random_value());
        issue(CMD_COMPUTE, 3'($urandom()), 3'($urandom()), random_value(), random_value());
    endtask

    // Stops sending and waits until every expected word is out and the block is idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (words_pending != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idling_on && cmd_count < CALM_FROM && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 16)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROWS_A:     rows_set  = data;
            REG_INNER_SIZE: inner_set = data;
            REG_COLS_B:     cols_set  = data;
            default: ;
        endcase
        reg_write_count++;
        @(posedge clk);
    endtask

    task automatic set_shape(logic [3:0] r, logic [3:0] k, logic [3:0] c);
        write_reg(REG_ROWS_A, r);
        write_reg(REG_INNER_SIZE, k);
        write_reg(REG_COLS_B, c);
    endtask

    // Upper data bits are random; only bit 0 of an enable register matters.
    task automatic set_mode(logic re_on, logic im_on);
        write_reg(REG_REAL_ENABLE, {3'($urandom()), re_on});
        write_reg(REG_IMAG_ENABLE, {3'($urandom()), im_on});
    endtask

    initial
    begin
        int  n;
        int  m;
        int  sel;
        bit  first_phase;
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rows_set        = 4'd8;
        inner_set       = 4'd8;
        cols_set        = 4'd8;
        foreach (a_loaded[i])
        begin
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
        end
        idling_on       = 1'b1;
        cmd_count       = 0;
        product_count   = 0;
        ignored_count   = 0;
        reg_write_count = 0;
        quiet_cycles    = 0;
        first_phase     = 1'b1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 1x1x1 products on the corner values, writes past the register list,
        // the unused command, every part mode, zero sizes and a small odd shape.
        set_shape(4'd1, 4'd1, 4'd1);
        write_reg(REG_PAST_END, '1);
        write_reg(REG_TOP_INDEX, '0);
        issue(CMD_LOAD_A, 3'd0, 3'd0, 16'h8000, 16'h8000);
        issue(CMD_LOAD_B, 3'd0, 3'd0, 16'h8000, 16'h7fff);
        compute_product();
        issue(CMD_UNUSED, 3'd7, 3'd7, 16'hffff, 16'hffff);
        issue(CMD_LOAD_A, 3'd0, 3'd0, 16'h7fff, 16'h7fff);
        issue(CMD_LOAD_B, 3'd0, 3'd0, 16'h7fff, 16'h8000);
        // Outside the configured shape, yet stored and read once the shape grows.
        issue(CMD_LOAD_A, 3'd7, 3'd7, 16'h1234, 16'hedcb);
        compute_product();
        settle();
        set_mode(1'b1, 1'b0);
        compute_product();
        settle();
        set_mode(1'b0, 1'b1);
        compute_product();
        settle();
        set_mode(1'b0, 1'b0);
        compute_product();
        settle();
        set_mode(1'b1, 1'b1);
        set_shape(4'd0, 4'd0, 4'd0);
        compute_product();
        settle();
        set_shape(4'd2, 4'd3, 4'd2);
        compute_product();

        // Random phases: a new setting each time, then loads and products.
        while (cmd_count < ITEM_TARGET)
        begin
            settle();
            idling_on = ($urandom_range(0, 2) != 0);
            if (first_phase)
            begin
                set_shape(4'd15, 4'd9, 4'd15);
                first_phase = 1'b0;
            end
            else
                set_shape(pick_dim(), pick_dim(), pick_dim());
            m = $urandom_range(0, 9);
            case (m)
                0: set_mode(1'b1, 1'b0);
                1: set_mode(1'b0, 1'b1);
                2: set_mode(1'b0, 1'b0);
                default: set_mode(1'b1, 1'b1);
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(3'($urandom_range(REG_PAST_END, REG_TOP_INDEX)), 4'($urandom()));
            n = $urandom_range(6, 24);
            repeat (n)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 5)
                    compute_product();
                else if (sel == 5)
                    issue(CMD_UNUSED, 3'($urandom()), 3'($urandom()), random_value(),
                          random_value());
                else
                    load_random(sel < 18);
            end
            compute_product();
        end

        settle();
        $display("Sent %0d load and compute words (%0d products), %0d unused commands, %0d register writes.",
                 cmd_count, product_count, ignored_count, reg_write_count);
        $display("Compared %0d product words over shapes from 1 to 8 and every part mode.",
                 words_checked);
        if (mismatch_count == 0 && words_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[complex_matrix_multiply.f]
design/cmm_pkg.sv
design/cmm_mem.sv
design/cmm_seq.sv
design/cmm_mac.sv
design/complex_matrix_multiply.sv
verif/cmm_product_checker.sv
verif/tb_complex_matrix_multiply.sv
